### hdl/spq_pkg.sv
// Shared types and constants of the stable priority queue.
package spq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int DATA_W        = 32;
   localparam int PRIO_W        = 8;
   localparam int STATUS_W      = 2;
   localparam int OCC_W         = 5;

   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic [PRIO_W-1:0]        prio;
   } entry_type;

   // Command broadcast from the control to every cell.
   typedef struct packed {
      logic      enq;
      logic      deq;
      entry_type entry;
   } cmd_type;

endpackage

### hdl/spq_channels.sv
// Valid/ready channel interfaces for request and response items.
interface spq_req_if;
   import spq_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     op;
   logic signed [DATA_W-1:0] in_data;
   logic [PRIO_W-1:0]        in_priority;

   modport source (output valid, output op, output in_data, output in_priority,
                   input ready);
   modport sink   (input valid, input op, input in_data, input in_priority,
                   output ready);
endinterface

interface spq_rsp_if;
   import spq_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] out_data;
   logic [PRIO_W-1:0]        out_priority;
   logic [STATUS_W-1:0]      status;
   logic [OCC_W-1:0]         occupancy;

   modport source (output valid, output out_data, output out_priority,
                   output status, output occupancy, input ready);
   modport sink   (input valid, input out_data, input out_priority,
                   input status, input occupancy, output ready);
endinterface

### hdl/spq_cell.sv
// One slot of the sorted shift array with its insert decision.
module spq_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 5
) (
   input  logic               clock,
   input  spq_pkg::cmd_type   cmd,
   input  logic [CNT_W-1:0]   count,
   input  logic               left_ins,
   input  spq_pkg::entry_type left_entry,
   input  spq_pkg::entry_type right_entry,
   output logic               ins,
   output spq_pkg::entry_type entry
);
   import spq_pkg::*;

   localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

   entry_type entry_ff;
   entry_type entry_in;

   // The array is sorted, so the insert flags form a run from the insert
   // position up to the first free slot.
   assign ins = ((IDX < count) && (entry_ff.prio > cmd.entry.prio)) || (IDX == count);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.enq && ins) begin
         entry_in = left_ins ? left_entry : cmd.entry;
      end else if (cmd.deq) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
endmodule

### hdl/stable_priority_queue.sv
// Stable bounded priority queue: a chain of sorted slots, smallest priority out first.
// Each request item is an enqueue or a dequeue and yields one response item
// with status and the count held afterward. One item is taken per clock: every
// slot compares its priority with the incoming one in parallel and shifts
// toward its neighbor in the same cycle. The slots and the response register
// are loaded at the same edge, so the response item can be taken from the
// next cycle on. The response register frees while its item is taken, so the
// input stalls only in reset or while a response item waits. Equal priorities leave in
// arrival order; an enqueue on a full queue is dropped and flagged.
module stable_priority_queue #(
   parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
   input  logic  clock,
   input  logic  reset,
   spq_req_if.sink   req_bus,
   spq_rsp_if.source rsp_bus
);
   import spq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] out_data_ff, out_data_in;
   logic [PRIO_W-1:0]        out_prio_ff, out_prio_in;
   status_type               status_ff, status_in;
   logic [OCC_W-1:0]         occ_ff;

   logic      accept;
   logic      full;
   logic      empty;
   cmd_type   cmd;
   logic      ins   [DEPTH];
   entry_type slot  [DEPTH];

   assign req_bus.ready = !reset && (!rsp_valid_ff || rsp_bus.ready);
   assign accept        = req_bus.valid && req_bus.ready;
   assign full          = (count_ff == FULL_CNT);
   assign empty         = (count_ff == '0);

   always_comb begin
      cmd.enq        = accept && (req_bus.op == OP_ENQUEUE) && !full;
      cmd.deq        = accept && (req_bus.op == OP_DEQUEUE) && !empty;
      cmd.entry.data = req_bus.in_data;
      cmd.entry.prio = req_bus.in_priority;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic      left_ins;
      entry_type left_entry;
      entry_type right_entry;

      if (i == 0) begin : g_first
         assign left_ins   = 1'b0;
         assign left_entry = cmd.entry;
      end else begin : g_mid
         assign left_ins   = ins[i-1];
         assign left_entry = slot[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_entry = slot[i];
      end else begin : g_inner
         assign right_entry = slot[i+1];
      end

      spq_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .count       (count_ff),
         .left_ins    (left_ins),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .ins         (ins[i]),
         .entry       (slot[i])
      );
   end

   always_comb begin
      count_in    = count_ff;
      out_data_in = '0;
      out_prio_in = '0;
      status_in   = ST_OK;
      if (req_bus.op == OP_ENQUEUE) begin
         if (full) begin
            status_in = ST_FULL;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end else begin
         if (empty) begin
            status_in = ST_EMPTY;
         end else begin
            count_in    = count_ff - CNT_W'(1);
            out_data_in = slot[0].data;
            out_prio_in = slot[0].prio;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         out_data_ff <= out_data_in;
         out_prio_ff <= out_prio_in;
         status_ff   <= status_in;
         occ_ff      <= OCC_W'(count_in);
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.out_data     = out_data_ff;
   assign rsp_bus.out_priority = out_prio_ff;
   assign rsp_bus.status       = status_ff;
   assign rsp_bus.occupancy    = occ_ff;
endmodule

### tb/tb_stable_priority_queue.sv
// Self-checking testbench for the stable priority queue: directed table, then random traffic.
module tb_stable_priority_queue;
   import spq_pkg::*;

   localparam int QUEUE_DEPTH    = DEPTH_DEFAULT;
   localparam int DIRECTED_ROWS  = 25;
   localparam int SEGMENTS       = 10;
   localparam int SEGMENT_ITEMS  = 40;
   localparam int HOLD_OFF_HOLD  = 80;
   localparam int SETTLE_CYCLES  = 20;
   localparam int CYCLE_LIMIT    = 200_000;

   typedef enum int {
      MIX_FILL,
      MIX_DRAIN,
      MIX_EVEN
   } traffic_mix_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic [PRIO_W-1:0]        prio;
      status_type               status;
      logic [OCC_W-1:0]         occupancy;
   } queue_reply_type;

   typedef struct packed {
      op_type                   op;
      logic signed [DATA_W-1:0] data;
      logic [PRIO_W-1:0]        prio;
      logic                     known;
      queue_reply_type          reply;
   } directed_row_type;

   logic clock;
   logic reset;

   spq_req_if req_ch ();
   spq_rsp_if rsp_ch ();

   stable_priority_queue #(.DEPTH(QUEUE_DEPTH)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch)
   );

   entry_type        sorted_entries[$];
   queue_reply_type  pending_replies[$];
   directed_row_type directed_rows[DIRECTED_ROWS];
   int               mismatch_count = 0;
   int               cycle_count = 0;
   bit               hold_off_request = 0;
   bit               steady_traffic = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Sorted-list model: insert after every entry of equal or smaller priority.
   function automatic queue_reply_type apply_to_queue(op_type op, logic signed [DATA_W-1:0] data,
                                                      logic [PRIO_W-1:0] prio);
      queue_reply_type r;
      entry_type       fresh;
      entry_type       head;
      int              pos;
      r.data   = '0;
      r.prio   = '0;
      r.status = ST_OK;
      if (op == OP_ENQUEUE) begin
         if (sorted_entries.size() >= QUEUE_DEPTH) begin
            r.status = ST_FULL;
         end else begin
            pos = 0;
            while (pos < sorted_entries.size() && sorted_entries[pos].prio <= prio) pos++;
            fresh.data = data;
            fresh.prio = prio;
            sorted_entries.insert(pos, fresh);
         end
      end else if (sorted_entries.size() == 0) begin
         r.status = ST_EMPTY;
      end else begin
         head   = sorted_entries.pop_front();
         r.data = head.data;
         r.prio = head.prio;
      end
      r.occupancy = OCC_W'(sorted_entries.size());
      return r;
   endfunction

   task automatic send_request(op_type op, logic signed [DATA_W-1:0] data,
                               logic [PRIO_W-1:0] prio, logic known, queue_reply_type literal);
      queue_reply_type predicted;
      if (!steady_traffic && $urandom_range(0, 99) < 15) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.op          <= op;
      req_ch.in_data     <= data;
      req_ch.in_priority <= prio;
      do @(posedge clock); while (!req_ch.ready);
      predicted = apply_to_queue(op, data, prio);
      pending_replies.push_back(known ? literal : predicted);
   endtask

   task automatic wait_for_replies();
      req_ch.valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   function automatic logic [PRIO_W-1:0] pick_priority();
      case ($urandom_range(0, 3))
         0:       return PRIO_W'($urandom_range(0, 3));
         1:       return PRIO_W'($urandom);
         2:       return $urandom_range(0, 1) ? {PRIO_W{1'b1}} : '0;
         default: return PRIO_W'($urandom_range(120, 136));
      endcase
   endfunction

   // Stimulus.
   initial begin
      traffic_mix_type mix;
      int              enqueue_odds;
      queue_reply_type no_literal;
      no_literal = '0;

      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.op          <= OP_ENQUEUE;
      req_ch.in_data     <= '0;
      req_ch.in_priority <= '0;

      directed_rows[0] = '{OP_DEQUEUE, 32'sh7fff_ffff, 8'hff, 1'b1,
                           '{32'sd0, 8'd0, ST_EMPTY, 5'd0}};
      directed_rows[1] = '{OP_ENQUEUE, 32'sh8000_0000, 8'hff, 1'b1,
                           '{32'sd0, 8'd0, ST_OK, 5'd1}};
      directed_rows[2] = '{OP_ENQUEUE, 32'sh7fff_ffff, 8'h00, 1'b1,
                           '{32'sd0, 8'd0, ST_OK, 5'd2}};
      directed_rows[3] = '{OP_ENQUEUE, 32'shffff_ffff, 8'h00, 1'b1,
                           '{32'sd0, 8'd0, ST_OK, 5'd3}};
      // Dequeues carry junk in the entry fields, which must be ignored.
      directed_rows[4] = '{OP_DEQUEUE, 32'sh5a5a_5a5a, 8'ha5, 1'b1,
                           '{32'sh7fff_ffff, 8'h00, ST_OK, 5'd2}};
      directed_rows[5] = '{OP_DEQUEUE, 32'shffff_ffff, 8'hff, 1'b1,
                           '{32'shffff_ffff, 8'h00, ST_OK, 5'd1}};
      directed_rows[6] = '{OP_DEQUEUE, 32'sh0000_0000, 8'h00, 1'b1,
                           '{32'sh8000_0000, 8'hff, ST_OK, 5'd0}};
      directed_rows[7] = '{OP_DEQUEUE, 32'sh0000_0000, 8'h00, 1'b1,
                           '{32'sd0, 8'd0, ST_EMPTY, 5'd0}};
      // Fill to capacity with plenty of equal priorities.
      for (int i = 8; i < 24; i++) begin
         directed_rows[i] = '{OP_ENQUEUE, DATA_W'($urandom),
                              (i % 3 == 0) ? 8'd7 : PRIO_W'($urandom), 1'b0, no_literal};
      end
      directed_rows[24] = '{OP_ENQUEUE, 32'sh1234_5678, 8'h00, 1'b1,
                            '{32'sd0, 8'd0, ST_FULL, 5'(QUEUE_DEPTH)}};

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].op, directed_rows[i].data, directed_rows[i].prio,
                      directed_rows[i].known, directed_rows[i].reply);
      end

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         if (seg == 0)      mix = MIX_DRAIN;
         else if (seg == 1) mix = MIX_FILL;
         else if (seg == 3) mix = MIX_FILL;
         else               mix = traffic_mix_type'($urandom_range(0, 2));

         // Responses back up here while requests keep coming.
         if (seg == 3) hold_off_request = 1'b1;
         if (seg == 5) wait_for_replies();
         if (seg == SEGMENTS - 1) steady_traffic = 1'b1;

         case (mix)
            MIX_FILL:  enqueue_odds = 85;
            MIX_DRAIN: enqueue_odds = 15;
            default:   enqueue_odds = 50;
         endcase

         for (int n = 0; n < SEGMENT_ITEMS; n++) begin
            send_request(($urandom_range(0, 99) < enqueue_odds) ? OP_ENQUEUE : OP_DEQUEUE,
                         DATA_W'($urandom), pick_priority(), 1'b0, no_literal);
         end
      end

      wait_for_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Response side: random stalls, one long hold-off on request.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_HOLD) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else if (!steady_traffic && $urandom_range(0, 99) < 15) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      queue_reply_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_replies.size() == 0) begin
            $error("response item with no request outstanding");
            mismatch_count++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_ch.out_data !== want.data) begin
               $error("out_data: expected %0d, got %0d", want.data, rsp_ch.out_data);
               mismatch_count++;
            end
            if (rsp_ch.out_priority !== want.prio) begin
               $error("out_priority: expected %0d, got %0d", want.prio, rsp_ch.out_priority);
               mismatch_count++;
            end
            if (rsp_ch.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
               mismatch_count++;
            end
            if (rsp_ch.occupancy !== want.occupancy) begin
               $error("occupancy: expected %0d, got %0d", want.occupancy, rsp_ch.occupancy);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

endmodule

### filelist.f
hdl/spq_pkg.sv
hdl/spq_channels.sv
hdl/spq_cell.sv
hdl/stable_priority_queue.sv
tb/tb_stable_priority_queue.sv
